// ----- rtl/bounded_list_deque_macros.svh -----
// Assertion macros for the bounded list deque.
`ifndef BOUNDED_LIST_DEQUE_MACROS_SVH
`define BOUNDED_LIST_DEQUE_MACROS_SVH

// same-cycle implication
`define BLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bld_pkg.sv -----
// Shared types and request codes for the bounded list deque.
package bld_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 4;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [REQ_W-1:0]         req_t;

    localparam req_t REQ_PUSH_FRONT = 4'd0;
    localparam req_t REQ_PUSH_BACK  = 4'd1;
    localparam req_t REQ_POP_FRONT  = 4'd2;
    localparam req_t REQ_POP_BACK   = 4'd3;
    localparam req_t REQ_READ_AT    = 4'd4;
    localparam req_t REQ_READ_END   = 4'd5;
    localparam req_t REQ_INSERT     = 4'd6;
    localparam req_t REQ_ERASE      = 4'd7;
    localparam req_t REQ_REVERSE    = 4'd8;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic reverse;
    } row_ctrl_t;

endpackage

// ----- rtl/bld_row.sv -----
// Register row of list entries with parallel shift, insert and reverse.
module bld_row #(
    parameter int CAPACITY = 16,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic              clk,
    input  bld_pkg::row_ctrl_t ctrl,
    input  logic [IW-1:0]     at,
    input  logic [CW-1:0]     count,
    input  bld_pkg::data_t    wr_value,
    output bld_pkg::data_t    row [CAPACITY]
);
    import bld_pkg::*;

    data_t row_reg  [CAPACITY];
    data_t row_next [CAPACITY];

    always_comb
    begin
        logic [IW-1:0] rev_idx;
        rev_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            row_next[i] = row_reg[i];
            rev_idx = IW'(count - CW'(1) - CW'(i));
            if (ctrl.shift_up)
            begin
                if (IW'(i) == at)
                    row_next[i] = wr_value;
                else if (IW'(i) > at && CW'(i) <= count)
                    row_next[i] = row_reg[IW'((i + CAPACITY - 1) % CAPACITY)];
            end
            else if (ctrl.shift_down)
            begin
                if (IW'(i) >= at && CW'(i + 1) < count)
                    row_next[i] = row_reg[IW'((i + 1) % CAPACITY)];
            end
            else if (ctrl.reverse)
            begin
                if (CW'(i) < count)
                    row_next[i] = row_reg[rev_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            row_reg[i] <= row_next[i];
    end

    assign row = row_reg;

endmodule

// ----- rtl/bounded_list_deque.sv -----
// Bounded list deque top level: request decode, count, result register.
//
// One request is accepted per clock: start is taken whenever busy is low, and busy is
// high only in the first cycle after reset. Every request gives one result beat, shown
// on the result ports with done high in the cycle right after acceptance; the receiver
// cannot stall, so it must take the beat in that cycle. All shifts, inserts, erases and
// the reverse act on the whole register row in parallel. entry_count carries the low five
// bits of the count.
module bounded_list_deque #(
    parameter int CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bld_pkg::req_t               req_type,
    input  logic [bld_pkg::POS_W-1:0]   position,
    input  bld_pkg::data_t              item_value,
    output logic                        done,
    output bld_pkg::data_t              read_value,
    output logic                        error,
    output logic [bld_pkg::CNT_W-1:0]   entry_count,
    output logic                        is_empty,
    output bld_pkg::data_t              front_value,
    output bld_pkg::data_t              back_value
);
    import bld_pkg::*;

    `include "bounded_list_deque_macros.svh"

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    logic          busy_reg;
    logic          done_reg;
    logic          error_reg,  error_next;
    data_t         read_value_reg, read_value_next;
    logic [CW-1:0] count_reg,  count_next;

    data_t         row [CAPACITY];
    row_ctrl_t     ctrl;
    logic [IW-1:0] at;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] last_idx;
    logic [EW-1:0] pos_e;
    logic [EW-1:0] cnt_e;
    logic          accept;
    logic          full;
    logic          empty;
    logic          has_rd;

    assign accept   = start && !busy_reg;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_e    = EW'(position);
    assign cnt_e    = EW'(count_reg);
    assign last_idx = IW'(count_reg - CW'(1));

    always_comb
    begin
        ctrl       = '0;
        at         = '0;
        rd_idx     = '0;
        has_rd     = 1'b0;
        error_next = 1'b0;
        count_next = count_reg;
        unique case (req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                error_next = full;
                at = (req_type == REQ_PUSH_FRONT) ? '0 : IW'(count_reg);
                if (!full)
                begin
                    ctrl.shift_up = 1'b1;
                    count_next    = count_reg + CW'(1);
                end
            end
            REQ_POP_FRONT:
            begin
                error_next = empty;
                has_rd     = 1'b1;
                if (!empty)
                begin
                    ctrl.shift_down = 1'b1;
                    count_next      = count_reg - CW'(1);
                end
            end
            REQ_POP_BACK:
            begin
                error_next = empty;
                has_rd     = 1'b1;
                rd_idx     = last_idx;
                if (!empty)
                    count_next = count_reg - CW'(1);
            end
            REQ_READ_AT:
            begin
                error_next = (pos_e >= cnt_e);
                has_rd     = 1'b1;
                rd_idx     = IW'(pos_e);
            end
            REQ_READ_END:
            begin
                error_next = (pos_e == '0) || (pos_e > cnt_e);
                has_rd     = 1'b1;
                rd_idx     = IW'(cnt_e - pos_e);
            end
            REQ_INSERT:
            begin
                error_next = full || (pos_e > cnt_e);
                at = IW'(pos_e);
                if (!error_next)
                begin
                    ctrl.shift_up = 1'b1;
                    count_next    = count_reg + CW'(1);
                end
            end
            REQ_ERASE:
            begin
                error_next = (pos_e >= cnt_e);
                at = IW'(pos_e);
                if (!error_next)
                begin
                    ctrl.shift_down = 1'b1;
                    count_next      = count_reg - CW'(1);
                end
            end
            REQ_REVERSE:
            begin
                ctrl.reverse = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (!accept)
        begin
            ctrl       = '0;
            count_next = count_reg;
        end
        read_value_next = (has_rd && !error_next) ? row[rd_idx] : '0;
    end

    bld_row #(
        .CAPACITY (CAPACITY)
    ) u_row (
        .clk      (clk),
        .ctrl     (ctrl),
        .at       (at),
        .count    (count_reg),
        .wr_value (item_value),
        .row      (row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            done_reg  <= accept;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            error_reg      <= error_next;
            read_value_reg <= read_value_next;
        end
    end

    // status reflects the row after the request during the done beat
    assign busy        = busy_reg;
    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign error       = error_reg;
    assign entry_count = CNT_W'(count_reg);
    assign is_empty    = empty;
    assign front_value = empty ? '0 : row[0];
    assign back_value  = empty ? '0 : row[last_idx];

    `BLD_ASSERT_NEXT(a_done_follows_accept, accept, done, "no result beat after request")
    `BLD_ASSERT_NEXT(a_push_counts_up,
        accept && (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK) && !full,
        count_reg == $past(count_reg) + 1'b1, "push did not grow the list")
    `BLD_ASSERT_NOW(a_error_reads_zero, done && error, read_value == '0,
        "failed request returned data")
    `BLD_ASSERT_NEXT(a_idle_holds_count, !accept, $stable(count_reg),
        "count changed without a request")

endmodule

// ----- test/tb_bounded_list_deque.sv -----
// Self-checking testbench for the bounded list deque: directed table, then biased random requests.
`timescale 1ns / 100ps

module tb_bounded_list_deque;
    import bld_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 400;

    localparam req_t REQ_UNUSED_FIRST = 4'd9;
    localparam req_t REQ_UNUSED_LAST  = 4'd15;

    localparam data_t MAX_VALUE = 32'sh7fffffff;
    localparam data_t MIN_VALUE = 32'sh80000000;

    typedef enum {FILL_BIAS, DRAIN_BIAS, MIXED_BIAS} mix_t;

    typedef struct packed {
        data_t            read_value;
        logic             error;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        data_t            front_value;
        data_t            back_value;
    } deque_result_t;

    typedef struct {
        req_t             req;
        logic [POS_W-1:0] pos;
        data_t            value;
        bit               typed;
        deque_result_t    result;
    } directed_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req_type;
    logic [POS_W-1:0] position;
    data_t            item_value;
    logic             done;
    data_t            read_value;
    logic             error;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
    data_t            front_value;
    data_t            back_value;

    // expectation written into the table, travels with the beat it belongs to
    logic             row_typed;
    deque_result_t    row_result;

    data_t            list_entries [CAPACITY];
    int               list_count;
    deque_result_t    pending_results [$];
    int               fault_count;
    directed_row_t    directed_rows [25];

    bounded_list_deque #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .position(position),
        .item_value(item_value),
        .done(done),
        .read_value(read_value),
        .error(error),
        .entry_count(entry_count),
        .is_empty(is_empty),
        .front_value(front_value),
        .back_value(back_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic deque_result_t result_of(data_t rd, logic err, int cnt, data_t front,
                                                data_t back);
        deque_result_t r;
        r.read_value  = rd;
        r.error       = err;
        r.entry_count = cnt[CNT_W-1:0];
        r.is_empty    = (cnt == 0);
        r.front_value = front;
        r.back_value  = back;
        return r;
    endfunction

    function automatic directed_row_t row(req_t req, int pos, data_t value, bit typed,
                                          deque_result_t result);
        directed_row_t d;
        d.req    = req;
        d.pos    = pos[POS_W-1:0];
        d.value  = value;
        d.typed  = typed;
        d.result = result;
        return d;
    endfunction

    // Applies one request to the list copy and returns the beat it should produce.
    function automatic deque_result_t apply_request(req_t req, logic [POS_W-1:0] pos,
                                                    data_t value);
        deque_result_t r;
        int            at;
        data_t         tmp;
        r = '0;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT:
            begin
                at = (req == REQ_PUSH_FRONT) ? 0 :
                     (req == REQ_PUSH_BACK) ? list_count : int'(pos);
                if (list_count >= CAPACITY || at > list_count)
                    r.error = 1'b1;
                else
                begin
                    for (int i = list_count; i > at; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[at] = value;
                    list_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_ERASE:
            begin
                at = (req == REQ_POP_FRONT) ? 0 :
                     (req == REQ_POP_BACK) ? list_count - 1 : int'(pos);
                if (list_count == 0 || at >= list_count)
                    r.error = 1'b1;
                else
                begin
                    if (req != REQ_ERASE)
                        r.read_value = list_entries[at];
                    for (int i = at; i < list_count - 1; i++)
                        list_entries[i] = list_entries[i+1];
                    list_count--;
                end
            end
            REQ_READ_AT:
            begin
                if (int'(pos) >= list_count)
                    r.error = 1'b1;
                else
                    r.read_value = list_entries[pos];
            end
            REQ_READ_END:
            begin
                if (pos == '0 || int'(pos) > list_count)
                    r.error = 1'b1;
                else
                    r.read_value = list_entries[list_count - int'(pos)];
            end
            REQ_REVERSE:
            begin
                for (int i = 0; i < list_count / 2; i++)
                begin
                    tmp = list_entries[i];
                    list_entries[i] = list_entries[list_count - 1 - i];
                    list_entries[list_count - 1 - i] = tmp;
                end
            end
            default:
                ;
        endcase
        r.entry_count = list_count[CNT_W-1:0];
        r.is_empty    = (list_count == 0);
        r.front_value = (list_count == 0) ? '0 : list_entries[0];
        r.back_value  = (list_count == 0) ? '0 : list_entries[list_count - 1];
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        deque_result_t want;
        deque_result_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{read_value, error, entry_count, is_empty, front_value, back_value};
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: result beat with nothing outstanding", $realtime);
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.read_value !== want.read_value || got.error !== want.error ||
                        got.entry_count !== want.entry_count ||
                        got.is_empty !== want.is_empty ||
                        got.front_value !== want.front_value ||
                        got.back_value !== want.back_value)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("%0t: exp rd=%0d err=%0b cnt=%0d empty=%0b front=%0d back=%0d",
                                     $realtime, want.read_value, want.error, want.entry_count,
                                     want.is_empty, want.front_value, want.back_value);
                            $display("%0t: got rd=%0d err=%0b cnt=%0d empty=%0b front=%0d back=%0d",
                                     $realtime, got.read_value, got.error, got.entry_count,
                                     got.is_empty, got.front_value, got.back_value);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                want = apply_request(req_type, position, item_value);
                if (row_typed)
                    want = row_result;
                pending_results.insert(pending_results.size(), want);
            end
        end
    end

    task automatic send_request(req_t req, logic [POS_W-1:0] pos, data_t value, bit typed,
                                deque_result_t result);
        start      <= 1'b1;
        req_type   <= req;
        position   <= pos;
        item_value <= value;
        row_typed  <= typed;
        row_result <= result;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_for(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(mix_t mode);
        req_t             req;
        logic [POS_W-1:0] pos;
        data_t            value;
        int               grow_w;
        int               shrink_w;
        int               pick;
        grow_w   = (mode == FILL_BIAS) ? 70 : (mode == DRAIN_BIAS) ? 15 : 35;
        shrink_w = (mode == FILL_BIAS) ? 10 : (mode == DRAIN_BIAS) ? 60 : 35;
        pick = $urandom_range(0, 99);
        if (pick < grow_w)
        begin
            case ($urandom_range(0, 2))
                0: req = REQ_PUSH_FRONT;
                1: req = REQ_PUSH_BACK;
                default: req = REQ_INSERT;
            endcase
        end
        else if (pick < grow_w + shrink_w)
        begin
            case ($urandom_range(0, 2))
                0: req = REQ_POP_FRONT;
                1: req = REQ_POP_BACK;
                default: req = REQ_ERASE;
            endcase
        end
        else if (pick < 98)
        begin
            case ($urandom_range(0, 2))
                0: req = REQ_READ_AT;
                1: req = REQ_READ_END;
                default: req = REQ_REVERSE;
            endcase
        end
        else
            req = req_t'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        if ($urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, list_count + 1));
        else
            pos = POS_W'($urandom_range(0, 31));
        case ($urandom_range(0, 19))
            0: value = MAX_VALUE;
            1: value = MIN_VALUE;
            default: value = $urandom;
        endcase
        send_request(req, pos, value, 1'b0, '0);
    endtask

    initial
    begin
        mix_t mode;
        bit   quiet;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_PUSH_BACK;
        position    = '0;
        item_value  = '0;
        row_typed   = 1'b0;
        row_result  = '0;
        list_count  = 0;
        fault_count = 0;
        mode        = FILL_BIAS;
        quiet       = 1'b0;

        directed_rows = '{
            row(REQ_POP_FRONT,    0,  0,         1, result_of(0, 1, 0, 0, 0)),
            row(REQ_POP_BACK,     0,  0,         1, result_of(0, 1, 0, 0, 0)),
            row(REQ_READ_AT,      0,  0,         1, result_of(0, 1, 0, 0, 0)),
            row(REQ_READ_END,     1,  0,         1, result_of(0, 1, 0, 0, 0)),
            row(REQ_ERASE,        0,  0,         1, result_of(0, 1, 0, 0, 0)),
            row(REQ_REVERSE,      0,  0,         1, result_of(0, 0, 0, 0, 0)),
            row(REQ_UNUSED_LAST,  31, -1,        1, result_of(0, 0, 0, 0, 0)),
            row(REQ_INSERT,       1,  7,         1, result_of(0, 1, 0, 0, 0)),
            row(REQ_INSERT,       0,  MAX_VALUE, 1, result_of(0, 0, 1, MAX_VALUE, MAX_VALUE)),
            row(REQ_PUSH_FRONT,   0,  MIN_VALUE, 1, result_of(0, 0, 2, MIN_VALUE, MAX_VALUE)),
            row(REQ_PUSH_BACK,    0,  -1,        1, result_of(0, 0, 3, MIN_VALUE, -1)),
            row(REQ_INSERT,       1,  0,         1, result_of(0, 0, 4, MIN_VALUE, -1)),
            row(REQ_INSERT,       5,  9,         1, result_of(0, 1, 4, MIN_VALUE, -1)),
            row(REQ_READ_AT,      4,  0,         1, result_of(0, 1, 4, MIN_VALUE, -1)),
            row(REQ_READ_AT,      31, 0,         1, result_of(0, 1, 4, MIN_VALUE, -1)),
            row(REQ_READ_END,     0,  0,         1, result_of(0, 1, 4, MIN_VALUE, -1)),
            row(REQ_READ_END,     5,  0,         1, result_of(0, 1, 4, MIN_VALUE, -1)),
            row(REQ_READ_END,     4,  0,         1,
                result_of(MIN_VALUE, 0, 4, MIN_VALUE, -1)),
            row(REQ_READ_AT,      2,  0,         0, '0),
            row(REQ_REVERSE,      0,  0,         0, '0),
            row(REQ_POP_FRONT,    0,  0,         0, '0),
            row(REQ_ERASE,        1,  0,         0, '0),
            row(REQ_POP_BACK,     0,  0,         0, '0),
            row(REQ_READ_END,     31, 0,         0, '0),
            row(REQ_UNUSED_FIRST, 16, 0,         0, '0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < $size(directed_rows); k++)
        begin
            send_request(directed_rows[k].req, directed_rows[k].pos, directed_rows[k].value,
                         directed_rows[k].typed, directed_rows[k].result);
            idle_for((k < 10) ? 0 : pick_gap());
        end

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 40 == 0)
            begin
                mode  = (k == 0) ? FILL_BIAS : mix_t'($urandom_range(0, 2));
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (k == RANDOM_ITEMS / 2)
                wait_all_results();
            send_random(mode);
            idle_for(quiet ? 0 : pick_gap());
        end

        wait_all_results();
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("tb_bounded_list_deque OK");
        else
            $display("tb_bounded_list_deque NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_bounded_list_deque NOT OK");
        $finish;
    end

endmodule
